// ===== rtl/aip_pkg.sv =====
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants for the ASCII integer parser
// Holds the per-string parse state, the digit decode result and the
// character codes that the datapath compares against.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned NarrowW = 32;
  // Widest partial value: acc*16 + 15 fits in ValueW + 4 bits.
  localparam int unsigned SumW = ValueW + 4;

  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LX = 8'h78;
  localparam logic [7:0] CHAR_UX = 8'h58;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic              hex;
    logic [1:0]        pos;
    logic              failed;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic       letter;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t decode_digit(input logic [7:0] ch);
    digit_t d;
    d.valid  = 1'b0;
    d.letter = 1'b0;
    d.value  = 4'd0;
    if (ch >= CHAR_0 && ch <= CHAR_9) begin
      d.valid = 1'b1;
      d.value = 4'(ch - CHAR_0);
    end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
      d.valid  = 1'b1;
      d.letter = 1'b1;
      d.value  = 4'(ch - CHAR_LA + 8'd10);
    end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
      d.valid  = 1'b1;
      d.letter = 1'b1;
      d.value  = 4'(ch - CHAR_UA + 8'd10);
    end
    return d;
  endfunction

endpackage

// ===== rtl/aip_step.sv =====
// ----------------------------------------------------------------------------
// aip_step: one-character update of the parse state
// Decodes the character, detects the hex prefix, forms value*base + digit
// with shifts and adds, checks it against the selected limit and builds
// the result for the final character.
// ----------------------------------------------------------------------------
module aip_step (
  input  aip_pkg::parse_state_t        st,
  input  logic [7:0]                   character,
  input  logic                         last_char,
  input  logic                         wide_result,
  output aip_pkg::parse_state_t        st_nxt,
  output logic [aip_pkg::ValueW-1:0]   parsed_value,
  output logic                         ok
);
  import aip_pkg::*;

  digit_t            dig;
  logic              is_x;
  logic              prefix;
  logic              digit_ok;
  logic [SumW-1:0]   acc_ext;
  logic [SumW-1:0]   scaled;
  logic [SumW-1:0]   sum;
  logic              fits;
  parse_state_t      upd;

  assign dig    = decode_digit(character);
  assign is_x   = (character == CHAR_LX) || (character == CHAR_UX);
  assign prefix = (st.pos == POS_SECOND) && (st.acc == '0) && !st.hex && is_x;
  assign digit_ok = dig.valid && (st.hex || !dig.letter);

  assign acc_ext = {4'd0, st.acc};
  // Base 16 is a shift; base 10 is acc*8 + acc*2.
  assign scaled = st.hex ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
  assign sum    = scaled + {{(SumW-4){1'b0}}, dig.value};
  assign fits   = wide_result ? (sum[SumW-1:ValueW] == '0) : (sum[SumW-1:NarrowW] == '0);

  always_comb begin
    upd = st;
    if (!st.failed) begin
      priority if (prefix) begin
        // A bare "0x" is not a number.
        if (last_char) upd.failed = 1'b1;
        else upd.hex = 1'b1;
      end else if (!digit_ok || !fits) begin
        upd.failed = 1'b1;
      end else begin
        upd.acc = sum[ValueW-1:0];
      end
    end
    if (st.pos != POS_LATER) upd.pos = st.pos + 2'd1;
  end

  assign parsed_value = upd.failed ? '0 : upd.acc;
  assign ok           = !upd.failed;
  assign st_nxt       = last_char ? parse_state_t'('0) : upd;

endmodule

// ===== rtl/ascii_integer_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit: streaming ASCII decimal/hex integer parser
// Parses unsigned numbers one character per transaction, with a 0x/0X
// prefix selecting hexadecimal and a 32- or 64-bit limit.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one character per
//   transaction; in_last_char marks the final character of a string.
//   For every final character one transaction leaves on the output channel
//   with out_parsed_value and out_ok (value is zero when the string failed).
//   cfg_wr_en/cfg_wr_data write wide_result: 0 limits values to 32 bits,
//   1 to 64 bits. Write it only while no string is in flight.
//   Throughput is one character per cycle while the result register can take
//   each final character. A character is captured in the input register,
//   then the single-pass update stage writes the parse state and, for a
//   final character, the result register, which presents the result.
//   Reset clears all parse state and both valid bits and sets wide_result
//   to 1. When the receiver stalls, the result register holds; characters
//   that produce no result still advance, and the input stalls only when a
//   final character meets a full result register.
// ----------------------------------------------------------------------------
module ascii_integer_parser_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_character,
  input  logic                       in_last_char,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [aip_pkg::ValueW-1:0] out_parsed_value,
  output logic                       out_ok,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data
);
  import aip_pkg::*;

  logic              wide_r;
  logic              in_valid_r;
  logic [7:0]        char_r;
  logic              last_r;
  parse_state_t      st_r;
  parse_state_t      st_nxt;
  logic              out_valid_r;
  logic [ValueW-1:0] value_r;
  logic              ok_r;
  logic [ValueW-1:0] value_nxt;
  logic              ok_nxt;
  logic              advance;
  logic              load_out;

  aip_step u_step (
    .st           (st_r),
    .character    (char_r),
    .last_char    (last_r),
    .wide_result  (wide_r),
    .st_nxt       (st_nxt),
    .parsed_value (value_nxt),
    .ok           (ok_nxt)
  );

  // Only a final character needs room in the result register.
  assign advance  = in_valid_r && (!last_r || !out_valid_r || out_ready);
  assign load_out = advance && last_r;
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r      <= 1'b1;
      in_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) wide_r <= cfg_wr_data;
      if (in_ready) in_valid_r <= in_valid;
      if (advance) st_r <= st_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      char_r <= in_character;
      last_r <= in_last_char;
    end
    if (load_out) begin
      value_r <= value_nxt;
      ok_r    <= ok_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = value_r;
  assign out_ok           = ok_r;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (value_r == '0))
    else $error("failed string reported a nonzero value");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pos != 2'd3)
    else $error("character position passed saturation");

  a_hex_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hex |-> (st_r.pos == POS_LATER))
    else $error("hex mode set before the prefix was complete");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (st_r == parse_state_t'('0)))
    else $error("parse state not cleared after final character");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming ASCII integer parser
// Sends decimal and hex number text one character per transaction, predicts
// each parsed value and ok flag, and compares every output transaction in
// order. Covers both value limits, malformed text, idle and stall phases,
// and long output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import aip_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_CHARS  = 150;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ok;
  } parse_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_character;
  logic              in_last_char;
  logic              out_valid;
  logic              out_ready;
  logic [ValueW-1:0] out_parsed_value;
  logic              out_ok;
  logic              cfg_wr_en;
  logic              cfg_wr_data;

  // Predicted parse state and register copy.
  logic [ValueW-1:0] num_acc;
  logic              num_hex;
  logic [1:0]        num_pos;
  logic              num_failed;
  logic              limit_wide;

  parse_result_t expected_numbers[$];
  parse_result_t checked_want;
  logic [7:0]    text_buf[$];

  int in_idle_pct;
  int out_stall_pct;
  int hold_count;
  int hold_served;
  int hold_left;
  int error_count;
  int chars_sent;
  int strings_sent;
  int results_ok;
  int results_bad;

  ascii_integer_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_last_char     (in_last_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_parsed_value (out_parsed_value),
    .out_ok           (out_ok),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic void clear_number();
    num_acc    = '0;
    num_hex    = 1'b0;
    num_pos    = POS_FIRST;
    num_failed = 1'b0;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    $display("%0t ERROR: %s", $time, msg);
  endfunction

  // Applies one accepted character to the predicted state and queues a result
  // when the character ends a string.
  function automatic void advance_parse(logic [7:0] ch, logic last);
    logic [ValueW-1:0] dig;
    logic [ValueW-1:0] base;
    logic [ValueW-1:0] limit;
    logic              dig_ok;
    parse_result_t     res;
    if (!num_failed) begin
      if (num_pos == POS_SECOND && num_acc == '0 && !num_hex &&
          (ch == CHAR_LX || ch == CHAR_UX)) begin
        // A prefix with nothing after it is a failed string.
        if (last) num_failed = 1'b1;
        else num_hex = 1'b1;
      end else begin
        dig_ok = 1'b1;
        dig    = '0;
        if (ch >= CHAR_0 && ch <= CHAR_9) begin
          dig = ValueW'(ch - CHAR_0);
        end else if (num_hex && ch >= CHAR_LA && ch <= CHAR_LF) begin
          dig = ValueW'(ch - CHAR_LA + 8'd10);
        end else if (num_hex && ch >= CHAR_UA && ch <= CHAR_UF) begin
          dig = ValueW'(ch - CHAR_UA + 8'd10);
        end else begin
          dig_ok = 1'b0;
        end
        base  = num_hex ? 64'd16 : 64'd10;
        limit = limit_wide ? {ValueW{1'b1}} : (64'd1 << NarrowW) - 64'd1;
        if (!dig_ok) num_failed = 1'b1;
        else if (num_acc > (limit - dig) / base) num_failed = 1'b1;
        else num_acc = num_acc * base + dig;
      end
    end
    if (num_pos != POS_LATER) num_pos = num_pos + 2'd1;
    if (last) begin
      res.value = num_failed ? '0 : num_acc;
      res.ok    = !num_failed;
      expected_numbers.insert(expected_numbers.size(), res);
      clear_number();
    end
  endfunction

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_count) begin
      hold_served = hold_count;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_numbers.size() == 0) begin
        note_error($sformatf("unexpected result value %h ok %b",
                             out_parsed_value, out_ok));
      end else begin
        checked_want = expected_numbers.pop_front();
        if (checked_want.ok) results_ok++;
        else results_bad++;
        if (out_parsed_value !== checked_want.value)
          note_error($sformatf("parsed_value expected %h actual %h",
                               checked_want.value, out_parsed_value));
        if (out_ok !== checked_want.ok)
          note_error($sformatf("ok expected %b actual %b", checked_want.ok, out_ok));
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_char(logic [7:0] ch, logic last);
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    advance_parse(ch, last);
    chars_sent++;
    if (last) strings_sent++;
  endtask

  task automatic send_text_buf();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  function automatic void add_char(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void append_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void append_hex(logic [ValueW-1:0] v);
    string      s;
    logic [7:0] c;
    if ($urandom_range(1)) append_str("0x");
    else append_str("0X");
    if ($urandom_range(7) == 0) add_char(CHAR_0);
    s = $sformatf("%0h", v);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= CHAR_LA && c <= CHAR_LF && $urandom_range(1)) c = c - (CHAR_LA - CHAR_UA);
      add_char(c);
    end
  endfunction

  function automatic void append_number(logic [ValueW-1:0] v);
    if ($urandom_range(1)) append_str($sformatf("%0d", v));
    else append_hex(v);
  endfunction

  task automatic send_str(string s);
    text_buf.delete();
    append_str(s);
    send_text_buf();
  endtask

  // Mostly well-formed numbers with random content, plus values at the two
  // limits, corrupted numbers, raw noise and bare prefixes.
  task automatic build_random_text();
    int                kind;
    int                nb;
    int                pos;
    logic [ValueW-1:0] v;
    text_buf.delete();
    kind = $urandom_range(99);
    nb   = $urandom_range(1, 64);
    v    = {$urandom, $urandom};
    if (nb < 64) v = v & ((64'd1 << nb) - 64'd1);
    if (kind < 35) begin
      if ($urandom_range(9) == 0) append_str("00");
      append_str($sformatf("%0d", v));
    end else if (kind < 60) begin
      append_hex(v);
    end else if (kind < 70) begin
      if ($urandom_range(1)) v = 64'hFFFF_FFFE + $urandom_range(2);
      else v = {ValueW{1'b1}} - $urandom_range(2);
      append_number(v);
      if ($urandom_range(3) == 0) add_char(CHAR_0 + 8'($urandom_range(9)));
    end else if (kind < 85) begin
      append_number(v);
      pos = $urandom_range(text_buf.size() - 1);
      if ($urandom_range(1)) text_buf[pos] = 8'($urandom_range(255));
      else text_buf.insert(pos, CHAR_LX);
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(3))
        0: append_str("0x");
        1: append_str("0X");
        2: add_char(CHAR_0 + 8'($urandom_range(9)));
        default: append_str("0x0");
      endcase
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_numbers.size() != 0);
  endtask

  task automatic set_width(logic wide);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= wide;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    limit_wide = wide;
  endtask

  task automatic test_directed();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_str("7");
    send_str("0x");
    send_str("0XaF");
    // A bad character fails the string and later digits are ignored.
    send_char(CHAR_0 + 8'd1, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CHAR_0 + 8'd2, 1'b1);
    send_char(8'h00, 1'b1);
    send_str("x");
    set_width(1'b0);
    send_str("0x100000000");
  endtask

  task automatic test_random_phases();
    int idle_tab[4];
    int stall_tab[4];
    int start;
    idle_tab  = '{0, 71, 0, 27};
    stall_tab = '{0, 0, 71, 27};
    for (int ph = 0; ph < 4; ph++) begin
      set_width(ph % 2 == 0);
      in_idle_pct   = idle_tab[ph];
      out_stall_pct = stall_tab[ph];
      start         = chars_sent;
      while (chars_sent - start < PHASE_CHARS) begin
        build_random_text();
        send_text_buf();
      end
    end
  endtask

  // Short strings while the receiver is held off, so the result side fills
  // and the input channel has to stall.
  task automatic test_output_holdoff();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_count++;
    repeat (25) begin
      text_buf.delete();
      repeat ($urandom_range(1, 2)) add_char(CHAR_0 + 8'($urandom_range(9)));
      send_text_buf();
    end
  endtask

  task automatic test_sender_pause();
    set_width(1'b1);
    in_idle_pct   = 27;
    out_stall_pct = 27;
    repeat (2) begin
      repeat (6) begin
        build_random_text();
        send_text_buf();
      end
      wait_results_drained();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_character  = '0;
    in_last_char  = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_count    = 0;
    error_count   = 0;
    chars_sent    = 0;
    strings_sent  = 0;
    results_ok    = 0;
    results_bad   = 0;
    limit_wide    = 1'b1;
    clear_number();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_phases();
    test_output_holdoff();
    test_sender_pause();

    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d characters in %0d strings; %0d parsed ok, %0d rejected.",
             chars_sent, strings_sent, results_ok, results_bad);
    $display("Exercised both value limits, hex and decimal text, noise and back-pressure.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
